/* rtl/core/cfra_pkg.sv */
// Package for the circle fit residual accumulator.
// Holds widths, payload structs and the register index codes.
// Used by the channel interfaces and every module of the block.
`default_nettype none

package cfra_pkg;

    // Field widths.
    localparam int COORD_W          = 32;
    localparam int RADIUS_W         = 31;
    localparam int WEIGHT_W         = 17;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int RES_W            = 63;

    // Datapath widths.
    localparam int MAG_W       = COORD_W;              // |point - centre| per axis
    localparam int SQ_W        = 2 * MAG_W;            // square of one axis
    localparam int ROOT_W      = 34;                   // root of a sum below 2^66
    localparam int RADICAND_W  = 2 * ROOT_W;           // padded sum of squares
    localparam int REM_W       = ROOT_W + 4;           // partial remainder
    localparam int ROOT_STEPS  = ROOT_W;               // one root bit per step
    localparam int STEP_W      = $clog2(ROOT_STEPS);
    localparam int HALF_W      = 32;                   // partial product split
    localparam int PLO_W       = HALF_W + WEIGHT_FRAC_BITS;
    localparam int PHI_W       = (RES_W - HALF_W) + WEIGHT_FRAC_BITS;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;
    localparam logic [RES_W-1:0]    RES_MAX    = {RES_W{1'b1}};

    // Register index codes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X  = 2'd0,
        CFG_CENTER_Y  = 2'd1,
        CFG_RADIUS    = 2'd2,
        CFG_WEIGHTING = 2'd3
    } cfg_idx_t;

    // One input point.
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [WEIGHT_W-1:0]       point_weight;
        logic                      last_point;
    } point_t;

    // One result item.
    typedef struct packed {
        logic [RES_W-1:0] squared_residual;
        logic [RES_W-1:0] residual_sum;
        logic             sum_final;
    } result_t;

    // Work handed from the front to the back through the queue.
    typedef struct packed {
        logic [SQ_W-1:0]     sq_x;
        logic [SQ_W-1:0]     sq_y;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } work_t;

endpackage

`default_nettype wire

/* rtl/core/cfra_if.sv */
// Channel interfaces of the circle fit residual accumulator.
// Point, result and configuration channels; depends on cfra_pkg.
`default_nettype none

interface cfra_point_if;
    import cfra_pkg::*;

    logic   valid;
    logic   ready;
    point_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cfra_result_if;
    import cfra_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cfra_cfg_if;
    import cfra_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/core/cfra_front.sv */
// Front end: configuration registers and a three stage pipeline that takes
// points, forms the per axis squared offsets and the effective weight.
// Depends on cfra_pkg and cfra_if.
`default_nettype none

module cfra_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    cfra_point_if.sink                            point,
    cfra_cfg_if.sink                              cfg,
    output logic                                  push_valid,
    output cfra_pkg::work_t                       push_data,
    input  wire logic                             push_ready,
    output logic [cfra_pkg::RADIUS_W-1:0]         radius
);
    import cfra_pkg::*;

    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;
    logic [RADIUS_W-1:0]       radius_reg;
    logic                      weighting_reg;

    logic                      s1_valid_reg;
    point_t                    s1_point_reg;
    logic                      s2_valid_reg;
    logic [MAG_W-1:0]          s2_mx_reg;
    logic [MAG_W-1:0]          s2_my_reg;
    logic [WEIGHT_W-1:0]       s2_weight_reg;
    logic                      s2_last_reg;
    logic                      s3_valid_reg;
    work_t                     s3_work_reg;

    logic                      s1_ready;
    logic                      s2_ready;
    logic                      s3_ready;
    logic [COORD_W:0]          dx;
    logic [COORD_W:0]          dy;
    logic [COORD_W:0]          dx_abs;
    logic [COORD_W:0]          dy_abs;
    logic [WEIGHT_W-1:0]       weight_clamped;
    logic [WEIGHT_W-1:0]       weight_eff;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;
    assign radius    = radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            radius_reg    <= '0;
            weighting_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_CENTER_X:  center_x_reg  <= cfg.wdata[COORD_W-1:0];
                CFG_CENTER_Y:  center_y_reg  <= cfg.wdata[COORD_W-1:0];
                CFG_RADIUS:    radius_reg    <= cfg.wdata[RADIUS_W-1:0];
                CFG_WEIGHTING: weighting_reg <= cfg.wdata[0];
            endcase
        end
    end

    // A stage takes new data when it is empty or its content moves on.
    assign s3_ready    = !s3_valid_reg || push_ready;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign point.ready = s1_ready;

    // Exact offsets from the centre and their magnitudes.
    assign dx     = {s1_point_reg.point_x[COORD_W-1], s1_point_reg.point_x}
                  - {center_x_reg[COORD_W-1], center_x_reg};
    assign dy     = {s1_point_reg.point_y[COORD_W-1], s1_point_reg.point_y}
                  - {center_y_reg[COORD_W-1], center_y_reg};
    assign dx_abs = dx[COORD_W] ? (~dx + 1'b1) : dx;
    assign dy_abs = dy[COORD_W] ? (~dy + 1'b1) : dy;

    // Weights above one are clamped; with weighting off every point counts once.
    assign weight_clamped = (s1_point_reg.point_weight > WEIGHT_ONE) ?
                            WEIGHT_ONE : s1_point_reg.point_weight;
    assign weight_eff     = weighting_reg ? weight_clamped : WEIGHT_ONE;

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= point.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (s1_ready && point.valid)
        begin
            s1_point_reg <= point.data;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_mx_reg     <= dx_abs[MAG_W-1:0];
            s2_my_reg     <= dy_abs[MAG_W-1:0];
            s2_weight_reg <= weight_eff;
            s2_last_reg   <= s1_point_reg.last_point;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_work_reg.sq_x   <= SQ_W'(s2_mx_reg) * SQ_W'(s2_mx_reg);
            s3_work_reg.sq_y   <= SQ_W'(s2_my_reg) * SQ_W'(s2_my_reg);
            s3_work_reg.weight <= s2_weight_reg;
            s3_work_reg.last   <= s2_last_reg;
        end
    end

    assign push_valid = s3_valid_reg;
    assign push_data  = s3_work_reg;

endmodule

`default_nettype wire

/* rtl/core/cfra_queue.sv */
// Short first-in first-out queue of work items between front and back.
// Depends on cfra_pkg.
`default_nettype none

module cfra_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    input  wire cfra_pkg::work_t   push_data,
    output logic                   push_ready,
    output logic                   pop_valid,
    output cfra_pkg::work_t        pop_data,
    input  wire logic              pop_ready
);
    import cfra_pkg::*;

    work_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cfra_back.sv */
// Back end: bit-serial square root, residual square, weighting and the
// saturating running sum, with a registered result slot.
// Depends on cfra_pkg and cfra_if.
`default_nettype none

module cfra_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pop_valid,
    input  wire cfra_pkg::work_t              pop_data,
    output logic                              pop_ready,
    input  wire logic [cfra_pkg::RADIUS_W-1:0] radius,
    cfra_result_if.source                     result
);
    import cfra_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_MAG,
        ST_SQUARE,
        ST_SAT,
        ST_WMUL,
        ST_TERM,
        ST_ACC
    } state_t;

    state_t                state_reg;
    logic [RADICAND_W-1:0] rad_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [WEIGHT_W-1:0]   weight_reg;
    logic                  last_reg;
    logic [ROOT_W-1:0]     mag_reg;
    logic [SQ_W-1:0]       prod_reg;
    logic                  big_reg;
    logic [RES_W-1:0]      sq_reg;
    logic [PLO_W-1:0]      plo_reg;
    logic [PHI_W-1:0]      phi_reg;
    logic [RES_W-1:0]      term_reg;
    logic [RES_W-1:0]      running_reg;
    logic                  out_valid_reg;
    result_t               out_data_reg;

    logic [SQ_W:0]         radicand;
    logic [REM_W-1:0]      rem_shift;
    logic [REM_W-1:0]      trial;
    logic                  trial_fits;
    logic [ROOT_W:0]       diff;
    logic [ROOT_W:0]       diff_abs;
    logic [SQ_W-1:0]       scaled;
    logic [RES_W:0]        total;
    logic [RES_W-1:0]      sum_sat;
    logic                  slot_free;

    assign pop_ready    = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;
    assign slot_free    = !out_valid_reg || result.ready;

    // Sum of the two axis squares, exact.
    assign radicand = {1'b0, pop_data.sq_x} + {1'b0, pop_data.sq_y};

    // One step of the restoring square root: two radicand bits in, one root bit out.
    assign rem_shift  = {rem_reg[REM_W-3:0], rad_reg[RADICAND_W-1 -: 2]};
    assign trial      = REM_W'({root_reg, 2'b01});
    assign trial_fits = (rem_shift >= trial);

    // Distance minus radius, as a magnitude.
    assign diff     = {1'b0, root_reg} - (ROOT_W + 1)'(radius);
    assign diff_abs = diff[ROOT_W] ? (~diff + 1'b1) : diff;

    // Weighted term from the two partial products; it stays below the square.
    assign scaled = SQ_W'({phi_reg, {WEIGHT_FRAC_BITS{1'b0}}})
                  + SQ_W'(plo_reg[PLO_W-1:WEIGHT_FRAC_BITS]);

    // Saturating accumulation.
    assign total   = {1'b0, running_reg} + {1'b0, term_reg};
    assign sum_sat = total[RES_W] ? RES_MAX : total[RES_W-1:0];

    // Sequencer with the running sum and the result slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rad_reg       <= '0;
            root_reg      <= '0;
            rem_reg       <= '0;
            step_reg      <= '0;
            weight_reg    <= '0;
            last_reg      <= 1'b0;
            mag_reg       <= '0;
            prod_reg      <= '0;
            big_reg       <= 1'b0;
            sq_reg        <= '0;
            plo_reg       <= '0;
            phi_reg       <= '0;
            term_reg      <= '0;
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            // A taken result frees the slot unless the accumulate step refills it.
            if (out_valid_reg && result.ready && state_reg != ST_ACC)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        rad_reg    <= RADICAND_W'(radicand);
                        root_reg   <= '0;
                        rem_reg    <= '0;
                        step_reg   <= STEP_W'(ROOT_STEPS - 1);
                        weight_reg <= pop_data.weight;
                        last_reg   <= pop_data.last;
                        state_reg  <= ST_ROOT;
                    end
                end

                ST_ROOT:
                begin
                    rad_reg <= {rad_reg[RADICAND_W-3:0], 2'b00};
                    if (trial_fits)
                    begin
                        rem_reg  <= rem_shift - trial;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_shift;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_MAG;
                    end
                end

                ST_MAG:
                begin
                    mag_reg   <= diff_abs[ROOT_W-1:0];
                    state_reg <= ST_SQUARE;
                end

                ST_SQUARE:
                begin
                    prod_reg  <= SQ_W'(mag_reg[HALF_W-1:0]) * SQ_W'(mag_reg[HALF_W-1:0]);
                    big_reg   <= |mag_reg[ROOT_W-1:HALF_W];
                    state_reg <= ST_SAT;
                end

                ST_SAT:
                begin
                    sq_reg    <= (big_reg || prod_reg[SQ_W-1]) ? RES_MAX : prod_reg[RES_W-1:0];
                    state_reg <= ST_WMUL;
                end

                ST_WMUL:
                begin
                    plo_reg   <= PLO_W'(sq_reg[HALF_W-1:0])
                               * PLO_W'(weight_reg[WEIGHT_FRAC_BITS-1:0]);
                    phi_reg   <= PHI_W'(sq_reg[RES_W-1:HALF_W])
                               * PHI_W'(weight_reg[WEIGHT_FRAC_BITS-1:0]);
                    state_reg <= ST_TERM;
                end

                ST_TERM:
                begin
                    // Full weight passes the square through unchanged.
                    term_reg  <= weight_reg[WEIGHT_FRAC_BITS] ? sq_reg : scaled[RES_W-1:0];
                    state_reg <= ST_ACC;
                end

                ST_ACC:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg                 <= 1'b1;
                        out_data_reg.squared_residual <= sq_reg;
                        out_data_reg.residual_sum     <= sum_sat;
                        out_data_reg.sum_final        <= last_reg;
                        running_reg                   <= last_reg ? '0 : sum_sat;
                        state_reg                     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/circle_fit_residual_accumulator.sv */
// Top level of the circle fit residual accumulator: front end, work queue
// and back end. Depends on cfra_pkg, cfra_if, cfra_front, cfra_queue, cfra_back.
//
//   Channel  Role    Request carries
//   -------  ------  ------------------------------------------------------
//   point    sink    point_x, point_y, point_weight, last_point
//   result   source  squared_residual, residual_sum, sum_final
//   cfg      sink    index (0 center_x, 1 center_y, 2 radius, 3 weighting_on), wdata
//
// Each point occupies the back end for a load step, the bit-serial square root
// (one root bit per cycle), and then the residual square, the weighting and the
// accumulation; the back end takes no new point until it is back in idle.
// Reset clears configuration, the running sum and all valid state; no clearing pass.
// The front holds up to three points and the queue two while the back is busy;
// a stalled result holds the back end in its accumulate step.
`default_nettype none

module circle_fit_residual_accumulator (
    input  wire logic     clk,
    input  wire logic     rst_n,
    cfra_point_if.sink    point,
    cfra_result_if.source result,
    cfra_cfg_if.sink      cfg
);
    import cfra_pkg::*;

    logic                push_valid;
    work_t               push_data;
    logic                push_ready;
    logic                pop_valid;
    work_t               pop_data;
    logic                pop_ready;
    logic [RADIUS_W-1:0] radius;

    // Point intake and configuration.
    cfra_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .point      (point),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .radius     (radius)
    );

    // Decoupling queue.
    cfra_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    // Root, residual and sum.
    cfra_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .radius    (radius),
        .result    (result)
    );

endmodule

`default_nettype wire

/* rtl/core/cfra_checker.sv */
// Port level checks for the circle fit residual accumulator, bound to the
// top level. Depends on cfra_pkg and circle_fit_residual_accumulator.
`default_nettype none

module cfra_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              point_valid,
    input wire logic              point_ready,
    input wire logic              result_valid,
    input wire logic              result_ready,
    input wire cfra_pkg::result_t result_data
);
    import cfra_pkg::*;

    logic [3:0]       outstanding_reg;
    logic             open_cloud_reg;
    logic [RES_W-1:0] last_sum_reg;
    logic             point_take;
    logic             result_take;

    assign point_take  = point_valid && point_ready;
    assign result_take = result_valid && result_ready;

    // Requests accepted but not yet answered, and the sum seen last in a cloud.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
            open_cloud_reg  <= 1'b0;
            last_sum_reg    <= '0;
        end
        else
        begin
            if (point_take && !result_take)
            begin
                outstanding_reg <= outstanding_reg + 1'b1;
            end
            else if (result_take && !point_take)
            begin
                outstanding_reg <= outstanding_reg - 1'b1;
            end
            if (result_take)
            begin
                open_cloud_reg <= !result_data.sum_final;
                last_sum_reg   <= result_data.residual_sum;
            end
        end
    end

    // A waiting result stays offered.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result valid dropped while stalled");

    // A waiting result keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_data))
        else $error("result payload changed while stalled");

    // Every result answers an accepted point.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> outstanding_reg != 4'd0)
        else $error("result offered with no point outstanding");

    // Within one cloud the running sum never decreases.
    a_sum_grows: assert property (@(posedge clk) disable iff (!rst_n)
        result_take && open_cloud_reg |-> result_data.residual_sum >= last_sum_reg)
        else $error("running sum decreased inside a cloud");

endmodule

bind circle_fit_residual_accumulator cfra_checker u_cfra_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point.valid),
    .point_ready  (point.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

`default_nettype wire

/* sim/circle_fit_residual_accumulator_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the circle fit residual accumulator.
// Drives points and register writes through the cfra_if channels and checks every
// result against a predictor kept in this file. Depends on cfra_pkg, cfra_if and the RTL.

module circle_fit_residual_accumulator_test;
    import cfra_pkg::*;

    localparam int SETTLE_CYCLES    = 60;
    localparam int PHASES           = 8;
    localparam int PHASE_POINTS     = 160;
    localparam int QUIET_POINTS     = 40;      // points at the start of a phase with no gaps
    localparam int LONG_HOLD_AFTER  = 250;     // results seen before the long result stall
    localparam int LONG_HOLD_CYCLES = 1500;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int PROBE_COUNT      = 20;

    localparam logic [RES_W-1:0] ONE_SQ = 63'h1_0000_0000;   // 1.0 squared

    // One directed probe: the circle it runs against and one point.
    typedef struct packed {
        logic [31:0]         cx;
        logic [31:0]         cy;
        logic [31:0]         rad;
        logic                won;
        logic [31:0]         px;
        logic [31:0]         py;
        logic [WEIGHT_W-1:0] w;
        logic                last;
        logic                typed;
        logic [RES_W-1:0]    want_sq;
        logic [RES_W-1:0]    want_sum;
    } probe_t;

    probe_t probes [PROBE_COUNT] = '{
        // Reset configuration: the origin, unit points and the extreme corners.
        '{32'h0, 32'h0, 32'h0, 1'b0,
          32'h0, 32'h0, 17'h0, 1'b0, 1'b1, 63'h0, 63'h0},
        '{32'h0, 32'h0, 32'h0, 1'b0,
          32'h00010000, 32'h0, 17'h1FFFF, 1'b0, 1'b1, ONE_SQ, ONE_SQ},
        '{32'h0, 32'h0, 32'h0, 1'b0,
          32'h0, 32'hFFFF0000, 17'h0, 1'b1, 1'b1, ONE_SQ, ONE_SQ << 1},
        '{32'h0, 32'h0, 32'h0, 1'b0,
          32'h7FFFFFFF, 32'h7FFFFFFF, 17'h0, 1'b0, 1'b0, 63'h0, 63'h0},
        '{32'h0, 32'h0, 32'h0, 1'b0,
          32'h80000000, 32'h80000000, 17'h0, 1'b1, 1'b0, 63'h0, 63'h0},
        // Widest distance: the residual saturates, then the sum sticks until last.
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 1'b0,
          32'h80000000, 32'h80000000, 17'h0, 1'b0, 1'b1, RES_MAX, RES_MAX},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 1'b0,
          32'h0, 32'h0, 17'h0, 1'b0, 1'b0, 63'h0, 63'h0},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 1'b0,
          32'h7FFFFFFF, 32'h7FFFFFFF, 17'h0, 1'b1, 1'b1, 63'h0, RES_MAX},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 1'b0,
          32'h7FFFFFFF, 32'h7FFFFFFF, 17'h0, 1'b1, 1'b1, 63'h0, 63'h0},
        // Largest radius, written with the unused top bit set.
        '{32'h0, 32'h0, 32'hFFFFFFFF, 1'b0,
          32'h0, 32'h0, 17'h0, 1'b0, 1'b0, 63'h0, 63'h0},
        '{32'h0, 32'h0, 32'hFFFFFFFF, 1'b0,
          32'h7FFFFFFF, 32'h0, 17'h0, 1'b1, 1'b0, 63'h0, 63'h0},
        // Weighting on: full, zero, half and clamped weights.
        '{32'h0, 32'h0, 32'h0, 1'b1,
          32'h00010000, 32'h0, 17'h10000, 1'b0, 1'b1, ONE_SQ, ONE_SQ},
        '{32'h0, 32'h0, 32'h0, 1'b1,
          32'h00010000, 32'h0, 17'h0, 1'b0, 1'b1, ONE_SQ, ONE_SQ},
        '{32'h0, 32'h0, 32'h0, 1'b1,
          32'h00010000, 32'h0, 17'h08000, 1'b0, 1'b1, ONE_SQ, 63'h1_8000_0000},
        '{32'h0, 32'h0, 32'h0, 1'b1,
          32'h00010000, 32'h0, 17'h1FFFF, 1'b1, 1'b1, ONE_SQ, 63'h2_8000_0000},
        // Saturated residual scaled by a full weight stays saturated.
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 1'b1,
          32'h80000000, 32'h80000000, 17'h10000, 1'b0, 1'b1, RES_MAX, RES_MAX},
        '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 1'b1,
          32'h80000000, 32'h80000000, 17'h00001, 1'b1, 1'b0, 63'h0, 63'h0},
        '{32'h80000000, 32'h0, 32'h00010000, 1'b0,
          32'h7FFFFFFF, 32'h0, 17'h1FFFF, 1'b1, 1'b0, 63'h0, 63'h0},
        // Weighting off again: the weight is ignored.
        '{32'h0, 32'h0, 32'h0, 1'b0,
          32'h00010000, 32'h0, 17'h0, 1'b1, 1'b1, ONE_SQ, ONE_SQ},
        '{32'h0, 32'h0, 32'h0, 1'b0,
          32'hFFFF8000, 32'h0, 17'h0, 1'b1, 1'b1, ONE_SQ >> 2, ONE_SQ >> 2}
    };

    logic clk;
    logic rst_n;

    cfra_point_if  point_ch ();
    cfra_result_if result_ch ();
    cfra_cfg_if    cfg_ch ();

    circle_fit_residual_accumulator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predictor copy of the circle, the weighting switch and the running sum.
    logic signed [COORD_W-1:0] circ_cx;
    logic signed [COORD_W-1:0] circ_cy;
    logic [RADIUS_W-1:0]       circ_r;
    logic                      weight_en;
    logic [RES_W-1:0]          acc_sum;

    result_t awaited_residuals [$];
    result_t want;
    int      mismatches;
    int      results_seen;

    initial begin
        circ_cx      = '0;
        circ_cy      = '0;
        circ_r       = '0;
        weight_en    = 1'b0;
        acc_sum      = '0;
        mismatches   = 0;
        results_seen = 0;
    end

    // Clock.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Squared radial residual and running sum of one point; advances the sum.
    function automatic result_t circle_residual(input point_t p);
        logic signed [COORD_W:0] dx;
        logic signed [COORD_W:0] dy;
        logic [MAG_W-1:0]        ax;
        logic [MAG_W-1:0]        ay;
        logic [65:0]             dist_sq;
        logic [ROOT_W-1:0]       root;
        logic [ROOT_W-1:0]       trial;
        logic [67:0]             trial_sq;
        logic [ROOT_W-1:0]       mag;
        logic [67:0]             mag_sq;
        logic [RES_W-1:0]        sq;
        logic [RES_W-1:0]        term;
        logic [WEIGHT_W-1:0]     w;
        logic [79:0]             wprod;
        logic [63:0]             total;
        result_t                 r;
        dx = {p.point_x[COORD_W-1], p.point_x} - {circ_cx[COORD_W-1], circ_cx};
        dy = {p.point_y[COORD_W-1], p.point_y} - {circ_cy[COORD_W-1], circ_cy};
        ax = (dx < 0) ? MAG_W'(-dx) : MAG_W'(dx);
        ay = (dy < 0) ? MAG_W'(-dy) : MAG_W'(dy);
        dist_sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);

        // Floor square root, one bit at a time from the top.
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial    = root | (ROOT_W'(1) << b);
            trial_sq = 68'(trial) * 68'(trial);
            if (trial_sq <= 68'(dist_sq))
                root = trial;
        end

        mag    = (root >= ROOT_W'(circ_r)) ? root - ROOT_W'(circ_r) : ROOT_W'(circ_r) - root;
        mag_sq = 68'(mag) * 68'(mag);
        sq     = (mag_sq > 68'(RES_MAX)) ? RES_MAX : mag_sq[RES_W-1:0];

        // Weighted term, with the weight clamped to one.
        if (weight_en) begin
            w     = (p.point_weight > WEIGHT_ONE) ? WEIGHT_ONE : p.point_weight;
            wprod = 80'(sq) * 80'(w);
            term  = (wprod[79:WEIGHT_FRAC_BITS] > 64'(RES_MAX)) ?
                    RES_MAX : wprod[RES_W+WEIGHT_FRAC_BITS-1:WEIGHT_FRAC_BITS];
        end
        else begin
            term = sq;
        end

        total = 64'(acc_sum) + 64'(term);
        r.squared_residual = sq;
        r.residual_sum     = (total > 64'(RES_MAX)) ? RES_MAX : total[RES_W-1:0];
        r.sum_final        = p.last_point;
        acc_sum = p.last_point ? '0 : r.residual_sum;
        return r;
    endfunction

    // Sender gap: mostly none, sometimes short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one point and record its expected result once it is accepted.
    task automatic send_point(input point_t p, input logic typed,
                              input logic [RES_W-1:0] want_sq, input logic [RES_W-1:0] want_sum);
        result_t r;
        point_ch.valid <= 1'b1;
        point_ch.data  <= p;
        do @(posedge clk); while (!point_ch.ready);
        r = circle_residual(p);
        if (typed) begin
            r.squared_residual = want_sq;
            r.residual_sum     = want_sum;
        end
        awaited_residuals = {awaited_residuals, r};
    endtask

    // Drop valid for a number of cycles.
    task automatic rest(input int cycles);
        if (cycles > 0) begin
            point_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Stop sending and wait until the block has nothing left to deliver.
    task automatic drain_idle();
        point_ch.valid <= 1'b0;
        while (awaited_residuals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; valid is left high for a following write.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            CFG_CENTER_X:  circ_cx   = val;
            CFG_CENTER_Y:  circ_cy   = val;
            CFG_RADIUS:    circ_r    = val[RADIUS_W-1:0];
            CFG_WEIGHTING: weight_en = val[0];
            default: ;
        endcase
    endtask

    // Write the whole circle and the weighting switch.
    task automatic program_circle(input logic [31:0] cx, input logic [31:0] cy,
                                  input logic [31:0] rad, input logic [31:0] won);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_WEIGHTING, won);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result checker against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && result_ch.valid && result_ch.ready) begin
            results_seen <= results_seen + 1;
            if (awaited_residuals.size() == 0) begin
                $display("%0t: unexpected result sq=%h sum=%h final=%b", $time,
                         result_ch.data.squared_residual, result_ch.data.residual_sum,
                         result_ch.data.sum_final);
                mismatches++;
            end
            else begin
                want = awaited_residuals.pop_front();
                if (result_ch.data.squared_residual !== want.squared_residual) begin
                    $display("%0t: squared_residual expected %h got %h", $time,
                             want.squared_residual, result_ch.data.squared_residual);
                    mismatches++;
                end
                if (result_ch.data.residual_sum !== want.residual_sum) begin
                    $display("%0t: residual_sum expected %h got %h", $time,
                             want.residual_sum, result_ch.data.residual_sum);
                    mismatches++;
                end
                if (result_ch.data.sum_final !== want.sum_final) begin
                    $display("%0t: sum_final expected %b got %b", $time,
                             want.sum_final, result_ch.data.sum_final);
                    mismatches++;
                end
            end
        end
    end

    // Result receiver: random stalls, quiet stretches and one long hold-off.
    initial begin
        int  stall_left;
        int  quiet_left;
        int  roll;
        bit  held;
        stall_left = 0;
        quiet_left = 0;
        held       = 1'b0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (!held && results_seen >= LONG_HOLD_AFTER) begin
                held = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (quiet_left > 0) begin
                quiet_left--;
                result_ch.ready <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else begin
                roll = $urandom_range(0, 99);
                if (roll < 2) begin
                    quiet_left = $urandom_range(50, 200);
                    result_ch.ready <= 1'b1;
                end
                else if (roll < 70) begin
                    result_ch.ready <= 1'b1;
                end
                else if (roll < 97) begin
                    stall_left = $urandom_range(0, 3);
                    result_ch.ready <= 1'b0;
                end
                else begin
                    stall_left = $urandom_range(10, 40);
                    result_ch.ready <= 1'b0;
                end
            end
        end
    end

    // Stimulus: reset, directed probes, then random phases.
    initial begin
        point_t      p;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] rad;
        logic [31:0] won;
        int          roll;
        int          shift;
        int          wait_left;

        point_ch.valid = 1'b0;
        point_ch.data  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_CENTER_X;
        cfg_ch.wdata   = '0;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed probes; the circle is reprogrammed only when a probe changes it.
        foreach (probes[i]) begin
            if ({probes[i].cx, probes[i].cy, probes[i].rad[RADIUS_W-1:0], probes[i].won} !==
                {circ_cx, circ_cy, circ_r, weight_en}) begin
                drain_idle();
                program_circle(probes[i].cx, probes[i].cy, probes[i].rad,
                               {31'($urandom), probes[i].won});
            end
            p.point_x      = probes[i].px;
            p.point_y      = probes[i].py;
            p.point_weight = probes[i].w;
            p.last_point   = probes[i].last;
            send_point(p, probes[i].typed, probes[i].want_sq, probes[i].want_sum);
            rest(pick_gap());
        end

        // Random phases, each against its own circle.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_idle();
            case (phase)
                0: begin
                    cx  = 32'h7FFFFFFF;
                    cy  = 32'h80000000;
                    rad = 32'hFFFFFFFF;
                    won = $urandom | 32'd1;
                end
                1: begin
                    cx  = '0;
                    cy  = '0;
                    rad = '0;
                    won = $urandom & ~32'd1;
                end
                default: begin
                    cx = $urandom_range(0, 1) ? $urandom : 32'($signed($urandom) >>> 8);
                    cy = $urandom_range(0, 1) ? $urandom : 32'($signed($urandom) >>> 8);
                    case ($urandom_range(0, 3))
                        0: rad = $urandom;
                        1: rad = $urandom_range(0, 32'h00FFFFFF) | ($urandom & 32'h80000000);
                        2: rad = 32'h7FFFFFFF;
                        default: rad = $urandom_range(0, 32'h0000FFFF);
                    endcase
                    won = $urandom;
                end
            endcase
            program_circle(cx, cy, rad, won);

            for (int n = 0; n < PHASE_POINTS; n++) begin
                // Mostly points near the centre or near the circle, some anywhere.
                roll = $urandom_range(0, 9);
                if (roll < 2) begin
                    p.point_x = $urandom;
                    p.point_y = $urandom;
                end
                else begin
                    shift     = $urandom_range(0, 31);
                    p.point_x = circ_cx + ($signed($urandom) >>> shift);
                    p.point_y = circ_cy + ($signed($urandom) >>> shift);
                    if ($urandom_range(0, 1))
                        p.point_x = p.point_x + 32'(circ_r);
                end
                roll = $urandom_range(0, 9);
                if (roll < 7)
                    p.point_weight = WEIGHT_W'($urandom_range(0, 65536));
                else if (roll < 8)
                    p.point_weight = WEIGHT_ONE;
                else if (roll < 9)
                    p.point_weight = WEIGHT_W'($urandom_range(65537, 131071));
                else
                    p.point_weight = WEIGHT_W'($urandom);
                p.last_point = ($urandom_range(0, 15) == 0);
                send_point(p, 1'b0, '0, '0);

                // One pause mid-phase until every result is back.
                if (phase == 3 && n == PHASE_POINTS / 2)
                    drain_idle();
                else if (n >= QUIET_POINTS)
                    rest(pick_gap());
            end
        end

        // Wait for the remaining results, with a limit.
        point_ch.valid <= 1'b0;
        wait_left = DRAIN_LIMIT;
        while (awaited_residuals.size() != 0 && wait_left > 0) begin
            @(posedge clk);
            wait_left--;
        end
        if (awaited_residuals.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     awaited_residuals.size());
            mismatches++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("[circle_fit_residual_accumulator] OK");
        else
            $display("[circle_fit_residual_accumulator] ERROR");
        $finish;
    end

    // Run limit.
    initial begin
        #12000000;
        $display("%0t: run limit reached", $time);
        $display("[circle_fit_residual_accumulator] ERROR");
        $finish;
    end

endmodule
